// ----- rtl/assert_macros.svh -----
// Assertion macros for the verification-only checker (ttc_checker) of the calendar core.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, always active (reset behaviour).
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- rtl/ttc_pkg.sv -----
// Shared types and constants for the tick-count to calendar core.
// No dependencies; imported by ttc_date, the top level and ttc_checker.
package ttc_pkg;

  localparam int TICK_W      = 32;
  localparam int IN_TDATA_W  = 32;

  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int MDAY_W  = 5;
  localparam int WDAY_W  = 3;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int PACK_W  = 32;
  localparam int YY_W    = 6;

  localparam int FIELDS_W    = YEAR_W + MONTH_W + MDAY_W + WDAY_W + HOUR_W + MIN_W + SEC_W
                               + PACK_W;
  localparam int OUT_TDATA_W = ((FIELDS_W + 7) / 8) * 8;

  // day count never exceeds 2^32 / 86400
  localparam int DAY_W = 16;

  localparam int SECS_PER_DAY     = 86400;
  localparam int SECS_PER_MIN     = 60;
  localparam int MINS_PER_HOUR    = 60;
  localparam int DAYS_PER_WEEK    = 7;
  localparam int WEEKDAY_AT_EPOCH = 3;
  localparam int CENTURY_DAYS     = 36524;
  localparam int DAYS_PER_CYCLE   = 1461;
  localparam int DAYS_PER_YEAR    = 365;
  localparam int EPOCH_YEAR       = 2000;
  localparam int YEARS_PER_CENT   = 100;
  localparam int MONTHS_PER_YEAR  = 12;
  localparam int MARCH_MONTH      = 3;
  localparam int JAN_INDEX        = MONTHS_PER_YEAR - MARCH_MONTH + 1;

  typedef logic [8:0] doy_t;

  // first day of each month, counted from 1 March
  localparam doy_t MARCH_START [MONTHS_PER_YEAR] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [MDAY_W-1:0]  mday;
    logic [YY_W-1:0]    yy;
  } ttc_date_t;

endpackage

// ----- rtl/ttc_cdiv.sv -----
// Three-stage pipelined division by a constant: reciprocal multiply, back-multiply,
// single correction step. Depends on nothing; used by ttc_date and the top level.
module ttc_cdiv #(
  parameter int W = 32,
  parameter int D = 3
) (
  input  logic                                      clk,
  input  logic [2:0]                                en,
  input  logic [W-1:0]                              x,
  output logic [W-($clog2(D+1)-1)-1:0]              q,
  output logic [((D > 1) ? $clog2(D) : 1)-1:0]      r
);

  localparam int          K       = $clog2(D + 1) - 1;
  localparam bit          IS_POW2 = (D & (D - 1)) == 0;
  localparam int          S       = W + K;
  localparam int          QW      = W - K;
  localparam int          RW      = (D > 1) ? $clog2(D) : 1;
  localparam logic [63:0] MFULL   = (64'd1 << S) / 64'(D);
  localparam logic [W-1:0] MV     = MFULL[W-1:0];
  localparam logic [W-1:0] DV     = W'(D);

  logic [W-1:0]   x_r1, x_r2;
  logic [2*W-1:0] prod_r1, prod_nxt;
  logic [QW-1:0]  qa_r2, qa_nxt;
  logic [W-1:0]   back_r2, back_nxt;
  logic [QW-1:0]  q_r3, q_nxt;
  logic [RW-1:0]  r_r3, r_nxt;
  logic [W-1:0]   rem;

  always_comb begin
    if (IS_POW2) begin
      prod_nxt = {x, W'(0)};
    end else begin
      prod_nxt = (2*W)'(x) * (2*W)'(MV);
    end
  end

  // estimate is exact or one low
  assign qa_nxt   = prod_r1[S +: QW];
  assign back_nxt = W'(qa_nxt) * DV;

  always_comb begin
    rem   = x_r2 - back_r2;
    q_nxt = qa_r2;
    if (rem >= DV) begin
      q_nxt = qa_r2 + QW'(1);
      rem   = rem - DV;
    end
    r_nxt = (D > 1) ? rem[RW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r1    <= x;
      prod_r1 <= prod_nxt;
    end
    if (en[1]) begin
      x_r2    <= x_r1;
      qa_r2   <= qa_nxt;
      back_r2 <= back_nxt;
    end
    if (en[2]) begin
      q_r3 <= q_nxt;
      r_r3 <= r_nxt;
    end
  end

  assign q = q_r3;
  assign r = r_r3;

endmodule

// ----- rtl/ttc_date.sv -----
// Seven-stage day-count to civil date pipeline (century fix, 4-year split, month search).
// Depends on ttc_pkg and ttc_cdiv.
module ttc_date (
  input  logic                         clk,
  input  logic [6:0]                   en,
  input  logic [ttc_pkg::DAY_W-1:0]    days,
  output ttc_pkg::ttc_date_t           date
);
  import ttc_pkg::*;

  localparam int CYC_K = $clog2(DAYS_PER_CYCLE + 1) - 1;
  localparam int CYC_W = DAY_W - CYC_K;
  localparam int REM_W = $clog2(DAYS_PER_CYCLE);

  logic [DAY_W-1:0]   dc_r, dc_nxt;
  logic [CYC_W-1:0]   cyc_q, cyc_r;
  logic [REM_W-1:0]   rem_q;
  logic [1:0]         yi_r, yi_nxt;
  doy_t               doy_r, doy_nxt;
  logic [3:0]         mi;
  logic               carry;
  logic [7:0]         yoff_r, yoff_nxt;
  logic [7:0]         yy_full;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [MDAY_W-1:0]  mday_r, mday_nxt;
  ttc_date_t          date_r, date_nxt;

  // 2100 correction; the 400-year term is always zero for a 16-bit day count
  assign dc_nxt = days + DAY_W'(days >= DAY_W'(CENTURY_DAYS));

  ttc_cdiv #(.W(DAY_W), .D(DAYS_PER_CYCLE)) u_cyc_div (
    .clk (clk),
    .en  (en[3:1]),
    .x   (dc_r),
    .q   (cyc_q),
    .r   (rem_q)
  );

  always_comb begin
    priority if (rem_q >= REM_W'(3 * DAYS_PER_YEAR)) begin
      yi_nxt  = 2'd3;
      doy_nxt = 9'(rem_q - REM_W'(3 * DAYS_PER_YEAR));
    end else if (rem_q >= REM_W'(2 * DAYS_PER_YEAR)) begin
      yi_nxt  = 2'd2;
      doy_nxt = 9'(rem_q - REM_W'(2 * DAYS_PER_YEAR));
    end else if (rem_q >= REM_W'(DAYS_PER_YEAR)) begin
      yi_nxt  = 2'd1;
      doy_nxt = 9'(rem_q - REM_W'(DAYS_PER_YEAR));
    end else begin
      yi_nxt  = 2'd0;
      doy_nxt = 9'(rem_q);
    end
  end

  always_comb begin
    mi = '0;
    for (int i = 1; i < MONTHS_PER_YEAR; i++) begin
      if (doy_r >= MARCH_START[i]) begin
        mi = 4'(i);
      end
    end
    mday_nxt = MDAY_W'(doy_r - MARCH_START[mi] + 9'd1);
    carry    = (mi >= 4'(JAN_INDEX));
    if (carry) begin
      month_nxt = 4'(mi + 4'(MARCH_MONTH) - 4'(MONTHS_PER_YEAR));
    end else begin
      month_nxt = 4'(mi + 4'(MARCH_MONTH));
    end
    yoff_nxt = 8'({cyc_r, 2'b00}) + 8'(yi_r) + 8'(carry);
  end

  always_comb begin
    if (yoff_r >= 8'(YEARS_PER_CENT)) begin
      yy_full = yoff_r - 8'(YEARS_PER_CENT);
    end else begin
      yy_full = yoff_r;
    end
    date_nxt.year  = YEAR_W'(EPOCH_YEAR) + YEAR_W'(yoff_r);
    date_nxt.month = month_r;
    date_nxt.mday  = mday_r;
    date_nxt.yy    = YY_W'(yy_full);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dc_r <= dc_nxt;
    end
    if (en[4]) begin
      cyc_r <= cyc_q;
      yi_r  <= yi_nxt;
      doy_r <= doy_nxt;
    end
    if (en[5]) begin
      month_r <= month_nxt;
      mday_r  <= mday_nxt;
      yoff_r  <= yoff_nxt;
    end
    if (en[6]) begin
      date_r <= date_nxt;
    end
  end

  assign date = date_r;

endmodule

// ----- rtl/timestamp_to_calendar_core.sv -----
// Tick count to calendar date and time, top level.
// Throughput one transaction per cycle while the output is not stalled.
// The main path is a chain of four 3-stage constant dividers (ticks/s, s/day, s/min, min/hour).
// Per-stage valid bits; a stalled output holds while empty stages keep filling.
// Synchronous active-low reset clears the valid bits only.
// Depends on ttc_pkg, ttc_cdiv and ttc_date.
module timestamp_to_calendar_core #(
  parameter int TICKS_PER_SECOND = 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ttc_pkg::IN_TDATA_W-1:0]   in_tdata,   // [31:0] tick_count
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [11:0] year_full, [15:12] month_number, [20:16] day_of_month, [23:21] day_of_week,
  // [28:24] hour_value, [34:29] minute_value, [40:35] second_value,
  // [72:41] packed_datetime, [79:73] zero
  output logic [ttc_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import ttc_pkg::*;

  localparam int NST     = 13;
  localparam int TPS_K   = $clog2(TICKS_PER_SECOND + 1) - 1;
  localparam int SECS_W  = TICK_W - TPS_K;
  localparam int DAY_K   = $clog2(SECS_PER_DAY + 1) - 1;
  localparam int DAYQ_W  = SECS_W - DAY_K;
  localparam int SOD_W   = $clog2(SECS_PER_DAY);
  localparam int MIN_K   = $clog2(SECS_PER_MIN + 1) - 1;
  localparam int MINS_W  = SOD_W - MIN_K;
  localparam int HRQ_W   = MINS_W - MIN_K;
  localparam int WK_IN_W = DAY_W + 1;
  localparam int DLY     = 4;

  logic [NST-1:0]     v_r;
  logic [NST-1:0]     en;

  logic [SECS_W-1:0]  secs_q;
  logic [DAYQ_W-1:0]  days_q;
  logic [SOD_W-1:0]   sod_q;
  logic [DAY_W-1:0]   days16;
  logic [MINS_W-1:0]  mins_q;
  logic [SEC_W-1:0]   sec_q;
  logic [HRQ_W-1:0]   hour_q;
  logic [MIN_W-1:0]   minute_q;
  logic [WDAY_W-1:0]  wday_q;

  logic [SEC_W-1:0]   sec_d_r  [DLY];
  logic [WDAY_W-1:0]  wday_d_r [DLY];
  logic [HOUR_W-1:0]  hour_r;
  logic [MIN_W-1:0]   minute_r;
  ttc_date_t          date;
  logic [PACK_W-1:0]  packed_dt;

  always_comb begin
    en[NST-1] = ~v_r[NST-1] | out_tready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = ~v_r[i] | en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NST-1];

  ttc_cdiv #(.W(TICK_W), .D(TICKS_PER_SECOND)) u_tps_div (
    .clk (clk),
    .en  (en[2:0]),
    .x   (in_tdata[TICK_W-1:0]),
    .q   (secs_q),
    .r   ()
  );

  ttc_cdiv #(.W(SECS_W), .D(SECS_PER_DAY)) u_day_div (
    .clk (clk),
    .en  (en[5:3]),
    .x   (secs_q),
    .q   (days_q),
    .r   (sod_q)
  );

  assign days16 = DAY_W'(days_q);

  ttc_cdiv #(.W(SOD_W), .D(SECS_PER_MIN)) u_min_div (
    .clk (clk),
    .en  (en[8:6]),
    .x   (sod_q),
    .q   (mins_q),
    .r   (sec_q)
  );

  ttc_cdiv #(.W(WK_IN_W), .D(DAYS_PER_WEEK)) u_wk_div (
    .clk (clk),
    .en  (en[8:6]),
    .x   (WK_IN_W'(days16) + WK_IN_W'(WEEKDAY_AT_EPOCH)),
    .q   (),
    .r   (wday_q)
  );

  ttc_date u_date (
    .clk  (clk),
    .en   (en[12:6]),
    .days (days16),
    .date (date)
  );

  ttc_cdiv #(.W(MINS_W), .D(MINS_PER_HOUR)) u_hr_div (
    .clk (clk),
    .en  (en[11:9]),
    .x   (mins_q),
    .q   (hour_q),
    .r   (minute_q)
  );

  always_ff @(posedge clk) begin
    if (en[9]) begin
      sec_d_r[0]  <= sec_q;
      wday_d_r[0] <= wday_q;
    end
    for (int j = 1; j < DLY; j++) begin
      if (en[9+j]) begin
        sec_d_r[j]  <= sec_d_r[j-1];
        wday_d_r[j] <= wday_d_r[j-1];
      end
    end
    if (en[NST-1]) begin
      hour_r   <= HOUR_W'(hour_q);
      minute_r <= minute_q;
    end
  end

  assign packed_dt = {date.yy, date.month, date.mday, hour_r, minute_r, sec_d_r[DLY-1]};

  assign out_tdata = {(OUT_TDATA_W - FIELDS_W)'(0), packed_dt, sec_d_r[DLY-1], minute_r,
                      hour_r, wday_d_r[DLY-1], date.mday, date.month, date.year};

endmodule

// ----- rtl/ttc_checker.sv -----
// Port-level checks for timestamp_to_calendar_core, attached by bind.
// Depends on ttc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ttc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [ttc_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ttc_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import ttc_pkg::*;

  `ASSERT_NEXT_ALWAYS(a_reset_clears, clk, !rst_n, !out_tvalid)

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  `ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)

  `ASSERT_IMPLY(a_field_range, clk, rst_n, out_tvalid, out_tdata[11:0] >= 12'd2000 && out_tdata[15:12] >= 4'd1 && out_tdata[15:12] <= 4'd12 && out_tdata[20:16] >= 5'd1 && out_tdata[23:21] <= 3'd6 && out_tdata[28:24] <= 5'd23 && out_tdata[34:29] <= 6'd59 && out_tdata[40:35] <= 6'd59)

  `ASSERT_IMPLY(a_packed_match, clk, rst_n, out_tvalid, out_tdata[66:63] == out_tdata[15:12] && out_tdata[62:58] == out_tdata[20:16] && out_tdata[57:53] == out_tdata[28:24] && out_tdata[52:47] == out_tdata[34:29] && out_tdata[46:41] == out_tdata[40:35])

endmodule

bind timestamp_to_calendar_core ttc_checker u_ttc_checker (.*);
